>>> rtl/baro_pkg.sv
// Shared types, constants and helper functions for the pressure compensation block.
package baro_pkg;

  localparam int DivW = 32;

  localparam logic [31:0] B6Off     = 32'd4000;
  localparam logic [31:0] KSq       = 32'd3038;
  localparam logic [31:0] KLin      = 32'hFFFF_E343;  // two's complement of 7357
  localparam logic [31:0] KOff      = 32'd3791;
  localparam logic [31:0] KScale    = 32'd50000;
  localparam logic [31:0] KHalf     = 32'd32768;
  localparam logic [17:0] PresMax   = 18'h3FFFF;

  typedef enum logic [2:0] {
    RegAcS = 3'd0,
    RegAcU = 3'd1,
    RegB   = 3'd2,
    RegM   = 3'd3,
    RegOs  = 3'd4
  } reg_idx_t;

  // per-item context that rides alongside the datapath
  typedef struct packed {
    logic        vld;
    logic        err;
    logic        neg;
    logic        post2;
    logic [31:0] val;
    logic [18:0] up;
  } ctx_t;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  os;
  } cal_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

>>> rtl/baro_pressure_temp_compensation.sv
// Top level: configuration registers, pipeline control and stage hookup.
// Pressure/temperature compensation pipeline. One item (raw temperature and raw
// pressure) is accepted per clock; its result passes through the two 32-stage
// bit-per-stage dividers and 11 arithmetic and register stages. The
// whole pipeline advances together; it holds only while a result sits at the
// output under stall. Calibration registers are written over the APB-style port
// (8-byte spacing, 64-bit data) and must be written only while the pipeline is
// empty. A zero divisor flags div_error with zero pressure and temperature.
module baro_pressure_temp_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_raw_temp,
  input  logic [18:0] in_raw_pressure,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [17:0] out_pressure_pa,
  output logic [15:0] out_temp_deci_c,
  output logic        out_div_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import baro_pkg::*;

  logic [47:0] ac_s_r;
  logic [47:0] ac_u_r;
  logic [31:0] b_r;
  logic [31:0] m_r;
  logic [1:0]  os_r;
  reg_idx_t    idx;
  logic        wr;
  logic        adv;
  cal_t        cal;

  ctx_t        d1_ctx_in, d1_ctx_out, d2_ctx_in, d2_ctx_out;
  logic [31:0] d1_dvd, d1_dsr, d1_quo, d2_dvd, d2_dsr, d2_quo;

  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac_s_r <= '0;
      ac_u_r <= '0;
      b_r    <= '0;
      m_r    <= '0;
      os_r   <= 2'd3;
    end else if (wr) begin
      unique case (idx)
        RegAcS:  ac_s_r <= pwdata[47:0];
        RegAcU:  ac_u_r <= pwdata[47:0];
        RegB:    b_r    <= pwdata[31:0];
        RegM:    m_r    <= pwdata[31:0];
        RegOs:   os_r   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegAcS:  prdata = {16'd0, ac_s_r};
      RegAcU:  prdata = {16'd0, ac_u_r};
      RegB:    prdata = {32'd0, b_r};
      RegM:    prdata = {32'd0, m_r};
      RegOs:   prdata = {62'd0, os_r};
      default: prdata = '0;
    endcase
  end

  assign cal = '{ac1: ac_s_r[47:32], ac2: ac_s_r[31:16], ac3: ac_s_r[15:0],
                 ac4: ac_u_r[47:32], ac5: ac_u_r[31:16], ac6: ac_u_r[15:0],
                 b1: b_r[31:16], b2: b_r[15:0], mc: m_r[31:16], md: m_r[15:0],
                 os: os_r};

  // advance everything unless a finished item is held at the output
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  baro_pre u_pre (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld(in_valid), .ut(in_raw_temp),
    .up(in_raw_pressure), .cal(cal), .ctx(d1_ctx_in), .dvd(d1_dvd), .dsr(d1_dsr)
  );

  baro_div u_div1 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_ctx(d1_ctx_in), .in_dvd(d1_dvd),
    .in_dsr(d1_dsr), .out_ctx(d1_ctx_out), .out_quo(d1_quo)
  );

  baro_mid u_mid (
    .clk(clk), .rst_n(rst_n), .en(adv), .cal(cal), .in_ctx(d1_ctx_out),
    .in_quo(d1_quo), .ctx(d2_ctx_in), .dvd(d2_dvd), .dsr(d2_dsr)
  );

  baro_div u_div2 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_ctx(d2_ctx_in), .in_dvd(d2_dvd),
    .in_dsr(d2_dsr), .out_ctx(d2_ctx_out), .out_quo(d2_quo)
  );

  baro_post u_post (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_ctx(d2_ctx_out), .in_quo(d2_quo),
    .vld(out_valid), .pres(out_pressure_pa), .temp(out_temp_deci_c),
    .err(out_div_error)
  );

endmodule

>>> rtl/baro_div.sv
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
module baro_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  baro_pkg::ctx_t   in_ctx,
  input  logic [31:0]      in_dvd,
  input  logic [31:0]      in_dsr,
  output baro_pkg::ctx_t   out_ctx,
  output logic [31:0]      out_quo
);
  import baro_pkg::*;

  ctx_t        ctx_r [DivW];
  logic [31:0] rem_r [DivW];
  logic [31:0] quo_r [DivW];
  logic [31:0] dsr_r [DivW];

  for (genvar i = 0; i < DivW; i++) begin : g_stage
    ctx_t        c_in;
    logic [31:0] rem_in;
    logic [31:0] quo_in;
    logic [31:0] dsr_in;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    if (i == 0) begin : g_first
      assign c_in   = in_ctx;
      assign rem_in = '0;
      assign quo_in = in_dvd;
      assign dsr_in = in_dsr;
    end else begin : g_next
      assign c_in   = ctx_r[i-1];
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign dsr_in = dsr_r[i-1];
    end

    assign trial = {rem_in, quo_in[31]};
    assign diff  = trial - {1'b0, dsr_in};
    assign ge    = trial >= {1'b0, dsr_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctx_r[i] <= '0;
      end else if (en) begin
        ctx_r[i] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[31:0] : trial[31:0];
        quo_r[i] <= {quo_in[30:0], ge};
        dsr_r[i] <= dsr_in;
      end
    end
  end

  assign out_ctx = ctx_r[DivW-1];
  assign out_quo = quo_r[DivW-1];

endmodule

>>> rtl/baro_pre.sv
// Temperature front end: raw temperature term and operands of the first division.
module baro_pre (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld,
  input  logic [15:0]      ut,
  input  logic [18:0]      up,
  input  baro_pkg::cal_t   cal,
  output baro_pkg::ctx_t   ctx,
  output logic [31:0]      dvd,
  output logic [31:0]      dsr
);
  import baro_pkg::*;

  logic        a_vld_r;
  logic [18:0] a_up_r;
  logic [31:0] a_prod_r;
  logic [31:0] prod_nxt;
  logic [31:0] x1;
  logic [31:0] den;
  logic [31:0] mc_x;
  logic [31:0] num;
  ctx_t        ctx_r;
  ctx_t        ctx_nxt;
  logic [31:0] dvd_r;
  logic [31:0] dsr_r;

  assign prod_nxt = 32'(({16'd0, ut} - {16'd0, cal.ac6}) * {16'd0, cal.ac5});

  assign x1   = asr32(a_prod_r, 5'd15);
  assign den  = x1 + sx16(cal.md);
  assign mc_x = sx16(cal.mc);
  assign num  = {mc_x[20:0], 11'd0};

  always_comb begin
    ctx_nxt       = '0;
    ctx_nxt.vld   = a_vld_r;
    ctx_nxt.err   = (den == '0);
    ctx_nxt.neg   = num[31] ^ den[31];
    ctx_nxt.val   = x1;
    ctx_nxt.up    = a_up_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      ctx_r   <= '0;
    end else if (en) begin
      a_vld_r <= vld;
      ctx_r   <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_up_r   <= up;
      a_prod_r <= prod_nxt;
      dvd_r    <= num[31] ? 32'(-num) : num;
      dsr_r    <= den[31] ? 32'(-den) : den;
    end
  end

  assign ctx = ctx_r;
  assign dvd = dvd_r;
  assign dsr = dsr_r;

endmodule

>>> rtl/baro_mid.sv
// Calibration core: B5 through B7 and the operands of the second division.
module baro_mid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  baro_pkg::cal_t   cal,
  input  baro_pkg::ctx_t   in_ctx,
  input  logic [31:0]      in_quo,
  output baro_pkg::ctx_t   ctx,
  output logic [31:0]      dvd,
  output logic [31:0]      dsr
);
  import baro_pkg::*;

  ctx_t        c4_r, c5_r, c6_r, c7_r, c8_r, c9_r;
  logic [31:0] b6_r;
  logic [31:0] sqp_r, m2_r, m3_r;
  logic [31:0] b2sq_r, b1sq_r, x2a_r, x1b_r;
  logic [31:0] b3_r, x3b_r;
  logic [31:0] b4p_r, diff_r;
  logic [31:0] b4_r, b7_r;

  logic [31:0] b5_nxt;
  logic [31:0] sq;
  logic [31:0] x3;
  logic [31:0] ac1_x;
  logic [31:0] n;
  logic [31:0] b3_nxt;
  logic [31:0] x3b_nxt;
  logic [31:0] b4_nxt;
  ctx_t        c4_nxt;
  ctx_t        c9_nxt;

  assign b5_nxt = in_ctx.val + (in_ctx.neg ? 32'(-in_quo) : in_quo);
  always_comb begin
    c4_nxt     = in_ctx;
    c4_nxt.val = b5_nxt;
  end

  assign sq = asr32(sqp_r, 5'd12);

  assign x3      = asr32(b2sq_r, 5'd11) + x2a_r;
  assign ac1_x   = sx16(cal.ac1);
  assign n       = (({ac1_x[29:0], 2'b00} + x3) << cal.os) + 32'd2;
  // divide by four toward zero
  assign b3_nxt  = asr32(n + (n[31] ? 32'd3 : 32'd0), 5'd2);
  assign x3b_nxt = asr32(x1b_r + asr32(b1sq_r, 5'd16) + 32'd2, 5'd2);

  assign b4_nxt = {15'd0, b4p_r[31:15]};
  always_comb begin
    c9_nxt     = c8_r;
    c9_nxt.err = c8_r.err | (b4_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
      c7_r <= '0;
      c8_r <= '0;
      c9_r <= '0;
    end else if (en) begin
      c4_r <= c4_nxt;
      c5_r <= c4_r;
      c6_r <= c5_r;
      c7_r <= c6_r;
      c8_r <= c7_r;
      c9_r <= c9_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b6_r   <= b5_nxt - B6Off;
      sqp_r  <= 32'(b6_r * b6_r);
      m2_r   <= 32'(sx16(cal.ac2) * b6_r);
      m3_r   <= 32'(sx16(cal.ac3) * b6_r);
      b2sq_r <= 32'(sx16(cal.b2) * sq);
      b1sq_r <= 32'(sx16(cal.b1) * sq);
      x2a_r  <= asr32(m2_r, 5'd11);
      x1b_r  <= asr32(m3_r, 5'd13);
      b3_r   <= b3_nxt;
      x3b_r  <= x3b_nxt;
      b4p_r  <= 32'({16'd0, cal.ac4} * (x3b_r + KHalf));
      diff_r <= {13'd0, c7_r.up} - b3_r;
      b4_r   <= b4_nxt;
      b7_r   <= 32'(diff_r * (KScale >> cal.os));
    end
  end

  // double before the divide unless the top bit is set, then double after
  always_comb begin
    ctx       = c9_r;
    ctx.post2 = b7_r[31];
  end
  assign dvd = b7_r[31] ? b7_r : {b7_r[30:0], 1'b0};
  assign dsr = b4_r;

endmodule

>>> rtl/baro_post.sv
// Output end: pressure correction polynomial, temperature, saturation and result register.
module baro_post (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  baro_pkg::ctx_t   in_ctx,
  input  logic [31:0]      in_quo,
  output logic             vld,
  output logic [17:0]      pres,
  output logic [15:0]      temp,
  output logic             err
);
  import baro_pkg::*;

  ctx_t        c11_r, c12_r;
  logic [31:0] p11_r, m1_r, m2_r;
  logic [31:0] p12_r, m3_r, x2_r;
  logic        vld_r;
  logic        err_r;
  logic [17:0] pres_r;
  logic [15:0] temp_r;

  logic [31:0] p_nxt;
  logic [31:0] p8;
  logic [31:0] pn;
  logic [31:0] t;
  logic [17:0] pres_nxt;
  logic [15:0] temp_nxt;

  assign p_nxt = in_ctx.post2 ? {in_quo[30:0], 1'b0} : in_quo;
  assign p8    = asr32(p_nxt, 5'd8);

  assign pn = p12_r + asr32(asr32(m3_r, 5'd16) + x2_r + KOff, 5'd4);
  assign t  = asr32(c12_r.val + 32'd8, 5'd4);

  always_comb begin
    if (pn[31]) begin
      pres_nxt = '0;
    end else if (pn[30:18] != '0) begin
      pres_nxt = PresMax;
    end else begin
      pres_nxt = pn[17:0];
    end
    if (t[31:15] == '0 || t[31:15] == '1) begin
      temp_nxt = t[15:0];
    end else begin
      temp_nxt = t[31] ? 16'h8000 : 16'h7FFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c11_r <= '0;
      c12_r <= '0;
      vld_r <= 1'b0;
    end else if (en) begin
      c11_r <= in_ctx;
      c12_r <= c11_r;
      vld_r <= c12_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p11_r  <= p_nxt;
      m1_r   <= 32'(p8 * p8);
      m2_r   <= 32'(p_nxt * KLin);
      p12_r  <= p11_r;
      m3_r   <= 32'(m1_r * KSq);
      x2_r   <= asr32(m2_r, 5'd16);
      err_r  <= c12_r.err;
      // zero both fields on a zero divisor
      pres_r <= c12_r.err ? '0 : pres_nxt;
      temp_r <= c12_r.err ? '0 : temp_nxt;
    end
  end

  assign vld  = vld_r;
  assign pres = pres_r;
  assign temp = temp_r;
  assign err  = err_r;

endmodule

>>> rtl/baro_chk.sv
// Port-level checks for the compensation block, bound to the top level.
module baro_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [17:0] out_pressure_pa,
  input logic [15:0] out_temp_deci_c,
  input logic        out_div_error,
  input logic        pready
);

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_error |-> out_pressure_pa == '0 && out_temp_deci_c == '0)
    else $error("error item carries nonzero fields");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled item dropped");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind baro_pressure_temp_compensation baro_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_pressure_pa(out_pressure_pa),
  .out_temp_deci_c(out_temp_deci_c), .out_div_error(out_div_error), .pready(pready)
);
